/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file (clds_checker.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define CLDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define CLDS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define CLDS_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/clds_pkg.sv */
package clds_pkg;

  localparam int unsigned LINE_CAPACITY = 256;
  localparam int unsigned CAP_W = 13;
  localparam int unsigned MAX_RESULTS = 5;

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_ECHO  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;

  localparam logic [1:0] REG_LINE_INPUT = 2'd0;
  localparam logic [1:0] REG_PROCESSED  = 2'd1;
  localparam logic [1:0] REG_ECHO       = 2'd2;
  localparam logic [1:0] REG_READ_LIMIT = 2'd3;

  typedef struct packed {
    logic       is_key_event;
    logic       key_down;
    logic [7:0] char_code;
    logic       queue_empty_after;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [8:0] position;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic       line_input_enable;
    logic       processed_input_enable;
    logic       echo_enable;
    logic [8:0] read_limit;
  } cfg_t;

  // results of one event, slot 0 goes out first
  typedef struct packed {
    logic [2:0]                      len;
    out_word_t [MAX_RESULTS-1:0]     slot;
  } burst_t;

endpackage

/* rtl/clds_decode.sv */
module clds_decode (
  input  clds_pkg::cfg_t     cfg,
  input  logic [8:0]         char_count,
  input  clds_pkg::in_word_t word,
  output clds_pkg::burst_t   burst,
  output logic [8:0]         char_count_next
);

  always_comb begin
    logic [8:0] lim;
    logic       key;
    logic       room;
    logic       plain;
    logic       bs_pop;
    logic       done;
    logic [1:0] n_store;
    logic [1:0] n_echo;
    logic [7:0] sb [2];
    logic [7:0] eb [2];
    logic [8:0] cc_after;
    logic [2:0] n;
    logic [7:0] ch;

    ch = word.char_code;
    key = word.is_key_event & word.key_down;

    // effective limit: zero acts as one, clamp to line capacity
    if (cfg.read_limit == 9'd0) begin
      lim = 9'd1;
    end else if ({4'd0, cfg.read_limit} > clds_pkg::CAP_W'(clds_pkg::LINE_CAPACITY)) begin
      lim = 9'(clds_pkg::LINE_CAPACITY);
    end else begin
      lim = cfg.read_limit;
    end

    room    = char_count < lim;
    plain   = 1'b0;
    bs_pop  = 1'b0;
    n_store = 2'd0;
    n_echo  = 2'd0;
    sb[0]   = '0;
    sb[1]   = '0;
    eb[0]   = '0;
    eb[1]   = '0;

    if (cfg.processed_input_enable) begin
      if (ch == clds_pkg::CH_NUL || ch == clds_pkg::CH_ETX) begin
        plain = 1'b0;
      end else if (ch == clds_pkg::CH_CR) begin
        if (cfg.line_input_enable && room) begin
          n_store = 2'd1;
          n_echo  = 2'd1;
          sb[0]   = clds_pkg::CH_CR;
          eb[0]   = clds_pkg::CH_CR;
          // LF only if it still fits
          if (({1'b0, char_count} + 10'd1) < {1'b0, lim}) begin
            n_store = 2'd2;
            n_echo  = 2'd2;
            sb[1]   = clds_pkg::CH_LF;
            eb[1]   = clds_pkg::CH_LF;
          end
        end
      end else if (ch == clds_pkg::CH_BS) begin
        if (char_count != 9'd0) begin
          bs_pop = 1'b1;
          n_echo = 2'd1;
          eb[0]  = clds_pkg::CH_BS;
        end
      end else begin
        plain = 1'b1;
      end
    end else begin
      plain = 1'b1;
    end

    if (plain && room) begin
      n_store = 2'd1;
      n_echo  = 2'd1;
      sb[0]   = ch;
      eb[0]   = ch;
    end

    cc_after = char_count + {7'd0, n_store} - {8'd0, bs_pop};

    done = cfg.line_input_enable ? (ch == clds_pkg::CH_CR) : word.queue_empty_after;
    if (cc_after >= lim) begin
      done = 1'b1;
    end

    burst = '0;
    n     = 3'd0;
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < n_store) begin
        burst.slot[n] = '{kind: clds_pkg::KIND_STORE, data_byte: sb[i],
                          position: char_count + 9'(i), last: 1'b0};
        n = n + 3'd1;
      end
    end
    if (cfg.echo_enable) begin
      for (int i = 0; i < 2; i++) begin
        if (2'(i) < n_echo) begin
          burst.slot[n] = '{kind: clds_pkg::KIND_ECHO, data_byte: eb[i],
                            position: 9'd0, last: 1'b0};
          n = n + 3'd1;
        end
      end
    end
    if (done) begin
      burst.slot[n] = '{kind: clds_pkg::KIND_DONE, data_byte: 8'd0,
                        position: cc_after, last: 1'b0};
      n = n + 3'd1;
    end
    if (n != 3'd0) begin
      burst.slot[n - 3'd1].last = 1'b1;
    end
    burst.len = n;

    char_count_next = done ? 9'd0 : cc_after;

    // dropped events leave no trace
    if (!key) begin
      burst           = '0;
      char_count_next = char_count;
    end
  end

endmodule

/* rtl/clds_burst.sv */
module clds_burst (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  clds_pkg::burst_t    load_burst,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output clds_pkg::out_word_t out_word
);

  clds_pkg::out_word_t [clds_pkg::MAX_RESULTS-1:0] slot;
  logic [2:0] len;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  // take a new burst when empty, or as the current one's final word moves to out_word
  assign can_load = (len == 3'd0) || (out_free && len == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (len != 3'd0) begin
          out_word  <= slot[0];
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end
      if (load) begin
        slot <= load_burst.slot;
        len  <= load_burst.len;
      end else if (out_free && len != 3'd0) begin
        for (int i = 0; i < clds_pkg::MAX_RESULTS - 1; i++) begin
          slot[i] <= slot[i+1];
        end
        len <= len - 3'd1;
      end
    end
  end

endmodule

/* rtl/console_line_discipline.sv */
// console_line_discipline: cooked-mode line editing of console key events.
//
// Input channel (in_valid/in_ready/in_word): one console event per word.
// Non-key events and key releases are consumed and produce nothing.
// Output channel (out_valid/out_ready/out_word): store, echo and completion
// words, in that order per event; last marks the final word of an event.
// Config port (cfg_we/cfg_index/cfg_data): single-cycle register writes; the
// user must write only while the block is idle, the block does not enforce it.
//
// An accepted event is held in the input register (in_q), its results go into
// the burst buffer, and from there each word is registered on out_word.
// Throughput: one event per cycle while each event yields at most one word and
// out_ready stays high; the single output register drains a burst of up to 5
// words one word a cycle while out_ready is high; the next event waits in in_q.
// Reset clears the byte count, the pipeline and restores the registers to
// line mode, processed input, echo on and a read limit of 256.
// A stalled receiver holds out_word; the burst buffer then fills and
// in_ready drops once the input register also holds a waiting event.
module console_line_discipline (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  clds_pkg::in_word_t in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output clds_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  clds_pkg::cfg_t     cfg;
  clds_pkg::in_word_t in_q;
  logic               in_q_valid;
  logic [8:0]         char_count;
  logic [8:0]         char_count_next;
  clds_pkg::burst_t   burst;
  logic               can_load;
  logic               consume;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_input_enable      <= 1'b1;
      cfg.processed_input_enable <= 1'b1;
      cfg.echo_enable            <= 1'b1;
      cfg.read_limit             <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        clds_pkg::REG_LINE_INPUT: cfg.line_input_enable      <= cfg_data[0];
        clds_pkg::REG_PROCESSED:  cfg.processed_input_enable <= cfg_data[0];
        clds_pkg::REG_ECHO:       cfg.echo_enable            <= cfg_data[0];
        clds_pkg::REG_READ_LIMIT: cfg.read_limit             <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register: decode reads it, result burst is loaded from it
  assign consume  = in_q_valid && can_load;
  assign in_ready = !in_q_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      char_count <= 9'd0;
    end else begin
      if (in_valid && in_ready) begin
        in_q_valid <= 1'b1;
      end else if (consume) begin
        in_q_valid <= 1'b0;
      end
      if (consume) begin
        char_count <= char_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_word;
    end
  end

  clds_decode u_decode (
    .cfg             (cfg),
    .char_count      (char_count),
    .word            (in_q),
    .burst           (burst),
    .char_count_next (char_count_next)
  );

  clds_burst u_burst (
    .clk        (clk),
    .rst        (rst),
    .load       (consume),
    .load_burst (burst),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

endmodule

/* rtl/clds_checker.sv */
`include "assert_macros.svh"

module clds_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input clds_pkg::out_word_t out_word
);

  `CLDS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))
  `CLDS_ASSERT_IMP(a_done_shape, clk, rst, out_valid && out_word.kind == clds_pkg::KIND_DONE, out_word.data_byte == 8'd0 && out_word.last)
  `CLDS_ASSERT_IMP(a_echo_pos, clk, rst, out_valid && out_word.kind == clds_pkg::KIND_ECHO, out_word.position == 9'd0)
  `CLDS_ASSERT_NXT_ALWAYS(a_reset_quiet, clk, rst, !out_valid)

endmodule

bind console_line_discipline clds_checker u_clds_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

/* tb/sv/console_line_discipline_test.sv */
module console_line_discipline_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Settling time after the last expected word: the first result passes the
  // input register and the burst buffer, and one event can yield five words.
  localparam int DRAIN_CYCLES   = 12;
  // Long receiver hold-off, long enough to back the block up until in_ready drops.
  localparam int HOLD_CYCLES    = 300;
  // Cycles with no word moving on either channel before we give up. The worst
  // correct stretch is the hold-off above plus random stalls at 66%.
  localparam int WATCHDOG_LIMIT = 4000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  clds_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  clds_pkg::out_word_t out_word;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = clds_pkg::REG_LINE_INPUT;
  logic [8:0]          cfg_data = '0;

  console_line_discipline u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Line discipline shadow: register copies plus the running byte count.
  // Matches the block's reset values.
  // ---------------------------------------------------------------------------
  logic       line_mode      = 1'b1;
  logic       processed_mode = 1'b1;
  logic       echo_on        = 1'b1;
  logic [8:0] read_limit     = 9'd256;
  logic [8:0] byte_count     = 9'd0;

  clds_pkg::out_word_t expected_words[$];   // words still owed by the block, oldest first
  int                  mismatch_count   = 0;
  int                  key_events_sent  = 0; // accepted key-down events
  int                  send_idle_pct    = 0;
  int                  recv_idle_pct    = 0;
  int                  hold_requests    = 0;
  int                  holds_served     = 0;
  int                  hold_left        = 0;
  int                  quiet_cycles     = 0;
  clds_pkg::out_word_t oldest_word;

  // Apply one accepted event to the shadow and queue the words it causes:
  // stores, then echoes, then the completion, with last on the final word.
  function automatic void predict_event(input clds_pkg::in_word_t ev);
    logic [8:0]          lim;
    logic [7:0]          echoes[$];
    clds_pkg::out_word_t words[$];
    clds_pkg::out_word_t w;
    logic                completes;
    logic                storable;
    if (!(ev.is_key_event && ev.key_down)) return;

    // zero acts as one, anything past the line buffer acts as its size
    if (read_limit == 9'd0) lim = 9'd1;
    else if (read_limit > 9'(clds_pkg::LINE_CAPACITY)) lim = 9'(clds_pkg::LINE_CAPACITY);
    else lim = read_limit;

    completes = line_mode ? (ev.char_code == clds_pkg::CH_CR) : ev.queue_empty_after;
    storable  = !processed_mode;

    if (processed_mode) begin
      case (ev.char_code)
        clds_pkg::CH_NUL, clds_pkg::CH_ETX: ; // dropped silently
        clds_pkg::CH_CR: begin
          // outside line mode a CR is dropped like NUL
          if (line_mode && byte_count < lim) begin
            words.push_back(clds_pkg::out_word_t'{clds_pkg::KIND_STORE, clds_pkg::CH_CR,
                                                  byte_count, 1'b0});
            byte_count++;
            echoes.push_back(clds_pkg::CH_CR);
            // LF only if it still fits; otherwise CR alone
            if (byte_count < lim) begin
              words.push_back(clds_pkg::out_word_t'{clds_pkg::KIND_STORE, clds_pkg::CH_LF,
                                                    byte_count, 1'b0});
              byte_count++;
              echoes.push_back(clds_pkg::CH_LF);
            end
          end
        end
        clds_pkg::CH_BS: begin
          if (byte_count != 9'd0) begin
            byte_count--;
            echoes.push_back(clds_pkg::CH_BS);
          end
        end
        default: storable = 1'b1;
      endcase
    end

    // no room left (limit lowered mid-read): neither stored nor echoed
    if (storable && byte_count < lim) begin
      words.push_back(clds_pkg::out_word_t'{clds_pkg::KIND_STORE, ev.char_code,
                                            byte_count, 1'b0});
      byte_count++;
      echoes.push_back(ev.char_code);
    end

    if (echo_on)
      foreach (echoes[i])
        words.push_back(clds_pkg::out_word_t'{clds_pkg::KIND_ECHO, echoes[i], 9'd0, 1'b0});

    if (byte_count >= lim) completes = 1'b1;
    if (completes) begin
      words.push_back(clds_pkg::out_word_t'{clds_pkg::KIND_DONE, 8'h00, byte_count, 1'b0});
      byte_count = 9'd0;
    end

    foreach (words[i]) begin
      w = words[i];
      w.last = (i == words.size() - 1);
      expected_words.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender. valid is left high after acceptance; the next call either reloads
  // the word or drops valid, so each step sees one assignment at most.
  // ---------------------------------------------------------------------------
  task automatic send_event(input clds_pkg::in_word_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= ev;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_event(ev);
    if (ev.is_key_event && ev.key_down) key_events_sent++;
  endtask

  function automatic clds_pkg::in_word_t key_press(input logic [7:0] ch,
                                                   input logic qe = 1'b0);
    return clds_pkg::in_word_t'{1'b1, 1'b1, ch, qe};
  endfunction

  // Mostly printable typing; some dropped events, control codes and raw bytes.
  function automatic clds_pkg::in_word_t random_event(input int cr_pct);
    clds_pkg::in_word_t ev;
    int                 pick;
    pick = $urandom_range(99);
    ev.is_key_event      = 1'b1;
    ev.key_down          = 1'b1;
    ev.queue_empty_after = ($urandom_range(3) == 0);
    ev.char_code         = 8'($urandom_range(8'h20, 8'h7e));
    if (pick < 8) begin
      // non-key event or key release (never both bits high)
      {ev.is_key_event, ev.key_down} = 2'($urandom_range(2));
      ev.char_code = 8'($urandom_range(255));
    end else if (pick < 8 + cr_pct) begin
      ev.char_code = clds_pkg::CH_CR;
    end else if (pick < 20 + cr_pct) begin
      case ($urandom_range(2))
        0: ev.char_code = clds_pkg::CH_NUL;
        1: ev.char_code = clds_pkg::CH_ETX;
        default: ev.char_code = clds_pkg::CH_BS;
      endcase
    end else if (pick < 40 + cr_pct) begin
      ev.char_code = 8'($urandom_range(255));
    end
    return ev;
  endfunction

  // Drop valid, let every owed word arrive, then cover events that make no
  // word but may still be inside the pipeline.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers back to back. Unused upper data bits on the
  // single-bit registers carry noise; only bit 0 counts.
  task automatic configure(input logic line_en, input logic proc_en,
                           input logic echo_en, input logic [8:0] limit);
    logic [1:0] regs[4];
    logic [8:0] value;
    regs = '{clds_pkg::REG_LINE_INPUT, clds_pkg::REG_PROCESSED,
             clds_pkg::REG_ECHO, clds_pkg::REG_READ_LIMIT};
    wait_idle();
    foreach (regs[i]) begin
      case (regs[i])
        clds_pkg::REG_LINE_INPUT: value = {8'($urandom_range(255)), line_en};
        clds_pkg::REG_PROCESSED:  value = {8'($urandom_range(255)), proc_en};
        clds_pkg::REG_ECHO:       value = {8'($urandom_range(255)), echo_en};
        default:                  value = limit;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= value;
      @(posedge clk);
    end
    cfg_we         <= 1'b0;
    line_mode      = line_en;
    processed_mode = proc_en;
    echo_on        = echo_en;
    read_limit     = limit;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus long hold-offs requested by the tests.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_ready    <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: every accepted word against the oldest owed word.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d data %h pos %0d last %0b",
                                  out_word.kind, out_word.data_byte,
                                  out_word.position, out_word.last));
      end else begin
        oldest_word = expected_words.pop_front();
        if (out_word.kind !== oldest_word.kind ||
            out_word.data_byte !== oldest_word.data_byte ||
            out_word.position !== oldest_word.position ||
            out_word.last !== oldest_word.last)
          report_mismatch($sformatf(
            "got kind %0d data %h pos %0d last %0b, want kind %0d data %h pos %0d last %0b",
            out_word.kind, out_word.data_byte, out_word.position, out_word.last,
            oldest_word.kind, oldest_word.data_byte, oldest_word.position,
            oldest_word.last));
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("** console_line_discipline: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default cooked line mode: dropped events, NUL/ctrl-c, backspace both with
  // and without something to erase, byte extremes, CR expanding to CRLF.
  task automatic test_cooked_line_editing();
    configure(1'b1, 1'b1, 1'b1, 9'd256);
    send_event(clds_pkg::in_word_t'{1'b0, 1'b1, 8'h61, 1'b1}); // not a key event
    send_event(clds_pkg::in_word_t'{1'b1, 1'b0, 8'h62, 1'b1}); // key release
    send_event(key_press(8'h41));
    send_event(key_press(clds_pkg::CH_NUL));
    send_event(key_press(clds_pkg::CH_ETX));
    send_event(key_press(clds_pkg::CH_BS));          // erases 'A'
    send_event(key_press(clds_pkg::CH_BS));          // nothing left, ignored
    send_event(key_press(8'hff));
    send_event(key_press(clds_pkg::CH_CR, 1'b1));    // CR LF, echoes, completion
  endtask

  // Raw input: control codes are stored as they are; CR still ends the line.
  task automatic test_raw_mode();
    configure(1'b1, 1'b0, 1'b1, 9'd256);
    send_event(key_press(clds_pkg::CH_NUL));
    send_event(key_press(clds_pkg::CH_BS));
    send_event(key_press(clds_pkg::CH_ETX, 1'b1));
    send_event(key_press(clds_pkg::CH_CR));
  endtask

  // Character mode without echo: completes when the event queue runs dry,
  // CR is dropped, and an empty read completes with count zero.
  task automatic test_queue_drained_completion();
    configure(1'b0, 1'b1, 1'b0, 9'd256);
    send_event(key_press(8'h78, 1'b0));
    send_event(key_press(clds_pkg::CH_CR, 1'b0));
    send_event(key_press(clds_pkg::CH_NUL, 1'b1));
    send_event(key_press(clds_pkg::CH_NUL, 1'b1));   // zero-byte completion
    send_event(key_press(8'h79, 1'b1));
  endtask

  // Read limit corners: CR with no room for LF, a limit of one, and a limit
  // lowered below the bytes already stored.
  task automatic test_read_limit_edges();
    configure(1'b1, 1'b1, 1'b1, 9'd2);
    send_event(key_press(8'h61));
    send_event(key_press(clds_pkg::CH_CR));          // CR only, then full
    configure(1'b1, 1'b1, 1'b1, 9'd1);
    send_event(key_press(8'h62));
    configure(1'b1, 1'b1, 1'b1, 9'd5);
    send_event(key_press(8'h61));
    send_event(key_press(8'h62));
    send_event(key_press(8'h63));
    configure(1'b1, 1'b1, 1'b1, 9'd2);
    send_event(key_press(8'h64));                    // no room: completion only
  endtask

  // Receiver holds off while the sender keeps offering, so in_ready drops;
  // nothing may be lost or reordered once it lets go.
  task automatic test_receiver_backpressure();
    int saved_pct;
    configure(1'b1, 1'b1, 1'b1, 9'd256);
    saved_pct     = send_idle_pct;
    send_idle_pct = 0;
    hold_requests++;
    repeat (40) send_event(random_event(0));
    send_event(key_press(clds_pkg::CH_CR));
    send_idle_pct = saved_pct;
  endtask

  task automatic type_line(input int n_chars);
    repeat (n_chars) send_event(random_event(0));
    send_event(key_press(clds_pkg::CH_CR, 1'($urandom_range(1))));
  endtask

  // Random register settings with small limits favored so reads complete
  // often; line mode mostly sees typed lines ending in CR.
  task automatic test_random_traffic(input int n_events);
    int         goal;
    int         stop_at;
    logic [8:0] lim;
    goal = key_events_sent + n_events;
    while (key_events_sent < goal) begin
      case ($urandom_range(5))
        0: lim = 9'd1;
        1: lim = 9'd256;
        2: lim = 9'($urandom_range(2, 4));
        3: lim = 9'($urandom_range(5, 20));
        default: lim = 9'($urandom_range(1, 256));
      endcase
      configure(1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)), lim);
      stop_at = key_events_sent + $urandom_range(20, 40);
      while (key_events_sent < stop_at && key_events_sent < goal) begin
        if (line_mode && $urandom_range(9) < 8) type_line($urandom_range(0, 10));
        else send_event(random_event(6));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 32;
    recv_idle_pct = 66;
    test_cooked_line_editing();
    test_raw_mode();
    test_queue_drained_completion();
    test_read_limit_edges();
    test_receiver_backpressure();
    test_random_traffic(90);

    send_idle_pct = 66;
    recv_idle_pct = 32;
    test_random_traffic(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(90);

    wait_idle();
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("** console_line_discipline: PASSED **");
    end else begin
      $display("** console_line_discipline: FAILED **");
    end
    $finish;
  end

endmodule
